// ----- design/sct_pkg.sv -----
// Shared types, constants and arithmetic helpers for the sine/cosine block.
`timescale 1ns / 1ps

package sct_pkg;

   localparam int TAYLOR_TERMS = 10;
   localparam int FRAC_BITS    = 16;
   localparam int MAX_HALVINGS = 5;

   localparam int ANGLE_W    = 22;
   localparam int OUT_W      = 18;
   localparam int DATA_W     = 24;
   localparam int PROD_W     = 2 * DATA_W;
   localparam int MAG_W      = ANGLE_W + 1;
   localparam int NCOEF      = 2 * TAYLOR_TERMS;
   localparam int COEF_IDX_W = $clog2(NCOEF);
   localparam int TERM_W     = $clog2(TAYLOR_TERMS);
   localparam int K_W        = $clog2(MAX_HALVINGS + 1);

   // pi/2 in Q.16, rounded half up
   localparam logic [MAG_W-1:0] HALF_PI = MAG_W'(102944);

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic [MAG_W-1:0]         mag_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_REDUCE,
      OP_SQUARE,
      OP_ACC_INIT,
      OP_HORNER,
      OP_SINE,
      OP_COSINE,
      OP_DA_SC,
      OP_DA_CC,
      OP_DA_SS,
      OP_EMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type             op;
      logic [K_W-1:0]        shift;
      logic [COEF_IDX_W-1:0] coef_idx;
   } cmd_type;

   typedef struct packed {
      logic halve_more;
   } status_type;

   // Reciprocal factorials 1/n! in Q.16, rounded half up
   function automatic data_type coef_of(input logic [COEF_IDX_W-1:0] idx);
      data_type c;
      unique case (idx)
         COEF_IDX_W'(0): c = DATA_W'(65536);
         COEF_IDX_W'(1): c = DATA_W'(65536);
         COEF_IDX_W'(2): c = DATA_W'(32768);
         COEF_IDX_W'(3): c = DATA_W'(10923);
         COEF_IDX_W'(4): c = DATA_W'(2731);
         COEF_IDX_W'(5): c = DATA_W'(546);
         COEF_IDX_W'(6): c = DATA_W'(91);
         COEF_IDX_W'(7): c = DATA_W'(13);
         COEF_IDX_W'(8): c = DATA_W'(2);
         default:        c = '0;
      endcase
      return c;
   endfunction

endpackage

// ----- design/sine_cosine_taylor_top.sv -----
// Top level of the fixed-point Taylor-series sine/cosine block.
// One item in flight at a time, set by the single shared multiplier:
//   9 Horner steps per series, and per halving (0 to 5 halvings) one
//   search step plus 3 double-angle products.
// The result register lets the next item be taken while a result waits.
// Reset (synchronous, active high) clears the sequencer and result valid only.
`timescale 1ns / 1ps

module sine_cosine_taylor_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [sct_pkg::ANGLE_W-1:0] req_angle,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [sct_pkg::OUT_W-1:0]   rsp_sine_out,
   output logic signed [sct_pkg::OUT_W-1:0]   rsp_cosine_out
);

   // Controller issues one datapath op per cycle; datapath reports the halving compare.
   sct_pkg::cmd_type    cmd;
   sct_pkg::status_type status;

   // Sequencer: idle -> halving search -> reduce -> x^2 -> sine Horner ->
   // cosine Horner -> k double-angle rounds -> emit into the result register.
   sct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // Working registers, coefficient table, shared rounding multiplier, result register.
   sct_datapath u_datapath (
      .clock          (clock),
      .req_angle      (req_angle),
      .cmd            (cmd),
      .status         (status),
      .rsp_sine_out   (rsp_sine_out),
      .rsp_cosine_out (rsp_cosine_out)
   );

endmodule

// ----- design/sct_ctrl.sv -----
// Sequencer for the sine/cosine block: halving search, Horner loops, double-angle loop.
`timescale 1ns / 1ps

module sct_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output sct_pkg::cmd_type    cmd,
   input  sct_pkg::status_type status
);

   typedef enum logic [13:0] {
      S_IDLE     = 14'b00000000000001,
      S_HALVE    = 14'b00000000000010,
      S_REDUCE   = 14'b00000000000100,
      S_SQUARE   = 14'b00000000001000,
      S_SIN_INIT = 14'b00000000010000,
      S_SIN_LOOP = 14'b00000000100000,
      S_SIN_FIN  = 14'b00000001000000,
      S_COS_INIT = 14'b00000010000000,
      S_COS_LOOP = 14'b00000100000000,
      S_COS_FIN  = 14'b00001000000000,
      S_DA_SC    = 14'b00010000000000,
      S_DA_CC    = 14'b00100000000000,
      S_DA_SS    = 14'b01000000000000,
      S_EMIT     = 14'b10000000000000
   } state_type;

   state_type                   state_ff, state_in;
   logic [sct_pkg::K_W-1:0]     k_ff, k_in;
   logic [sct_pkg::TERM_W-1:0]  term_ff, term_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      term_in      = term_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd.op       = sct_pkg::OP_NONE;
      cmd.shift    = k_ff;
      cmd.coef_idx = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = sct_pkg::OP_LOAD;
               k_in     = '0;
               state_in = S_HALVE;
            end
         end
         S_HALVE: begin
            if (k_ff < sct_pkg::K_W'(sct_pkg::MAX_HALVINGS) && status.halve_more) begin
               k_in = k_ff + 1'b1;
            end else begin
               state_in = S_REDUCE;
            end
         end
         S_REDUCE: begin
            cmd.op   = sct_pkg::OP_REDUCE;
            state_in = S_SQUARE;
         end
         S_SQUARE: begin
            cmd.op   = sct_pkg::OP_SQUARE;
            state_in = S_SIN_INIT;
         end
         S_SIN_INIT: begin
            cmd.op       = sct_pkg::OP_ACC_INIT;
            cmd.coef_idx = sct_pkg::COEF_IDX_W'(sct_pkg::NCOEF - 1);
            term_in      = sct_pkg::TERM_W'(sct_pkg::TAYLOR_TERMS - 2);
            state_in     = S_SIN_LOOP;
         end
         S_SIN_LOOP: begin
            cmd.op       = sct_pkg::OP_HORNER;
            cmd.coef_idx = sct_pkg::COEF_IDX_W'({term_ff, 1'b1});
            term_in      = term_ff - 1'b1;
            if (term_ff == '0) state_in = S_SIN_FIN;
         end
         S_SIN_FIN: begin
            cmd.op   = sct_pkg::OP_SINE;
            state_in = S_COS_INIT;
         end
         S_COS_INIT: begin
            cmd.op       = sct_pkg::OP_ACC_INIT;
            cmd.coef_idx = sct_pkg::COEF_IDX_W'(sct_pkg::NCOEF - 2);
            term_in      = sct_pkg::TERM_W'(sct_pkg::TAYLOR_TERMS - 2);
            state_in     = S_COS_LOOP;
         end
         S_COS_LOOP: begin
            cmd.op       = sct_pkg::OP_HORNER;
            cmd.coef_idx = sct_pkg::COEF_IDX_W'({term_ff, 1'b0});
            term_in      = term_ff - 1'b1;
            if (term_ff == '0) state_in = S_COS_FIN;
         end
         S_COS_FIN: begin
            cmd.op   = sct_pkg::OP_COSINE;
            state_in = (k_ff == '0) ? S_EMIT : S_DA_SC;
         end
         S_DA_SC: begin
            cmd.op   = sct_pkg::OP_DA_SC;
            state_in = S_DA_CC;
         end
         S_DA_CC: begin
            cmd.op   = sct_pkg::OP_DA_CC;
            state_in = S_DA_SS;
         end
         S_DA_SS: begin
            cmd.op   = sct_pkg::OP_DA_SS;
            k_in     = k_ff - 1'b1;
            state_in = (k_ff == sct_pkg::K_W'(1)) ? S_EMIT : S_DA_SC;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = sct_pkg::OP_EMIT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         k_ff         <= '0;
         term_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         term_ff      <= term_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_k_bound: assert property (@(posedge clock) disable iff (reset)
      k_ff <= sct_pkg::K_W'(sct_pkg::MAX_HALVINGS))
      else $error("halving count over budget");

   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && (!rsp_valid_ff || rsp_ready)) |=> rsp_valid_ff)
      else $error("result not presented after emit");

   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_HALVE && k_ff == '0))
      else $error("accepted item did not start halving search");

   a_term_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SIN_LOOP || state_ff == S_COS_LOOP)
         |-> term_ff <= sct_pkg::TERM_W'(sct_pkg::TAYLOR_TERMS - 2))
      else $error("Horner term index out of range");

endmodule

// ----- design/sct_datapath.sv -----
// Datapath for the sine/cosine block: one shared rounding multiplier and working registers.
`timescale 1ns / 1ps

module sct_datapath (
   input  logic                                clock,
   input  logic signed [sct_pkg::ANGLE_W-1:0]  req_angle,
   input  sct_pkg::cmd_type                    cmd,
   output sct_pkg::status_type                 status,
   output logic signed [sct_pkg::OUT_W-1:0]    rsp_sine_out,
   output logic signed [sct_pkg::OUT_W-1:0]    rsp_cosine_out
);

   localparam sct_pkg::data_type ONE = sct_pkg::DATA_W'(1) <<< sct_pkg::FRAC_BITS;

   // magnitude product, rounded half away from zero, sign applied after
   function automatic sct_pkg::data_type mulq(input sct_pkg::data_type a,
                                              input sct_pkg::data_type b);
      logic                        neg;
      logic [sct_pkg::DATA_W-1:0]  ua, ub, r;
      logic [sct_pkg::PROD_W-1:0]  p;
      neg = a[sct_pkg::DATA_W-1] ^ b[sct_pkg::DATA_W-1];
      ua  = a[sct_pkg::DATA_W-1] ? $unsigned(-a) : $unsigned(a);
      ub  = b[sct_pkg::DATA_W-1] ? $unsigned(-b) : $unsigned(b);
      p   = sct_pkg::PROD_W'(ua) * sct_pkg::PROD_W'(ub);
      p   = (p + (sct_pkg::PROD_W'(1) << (sct_pkg::FRAC_BITS - 1))) >> sct_pkg::FRAC_BITS;
      r   = p[sct_pkg::DATA_W-1:0];
      return neg ? -$signed(r) : $signed(r);
   endfunction

   function automatic sct_pkg::data_type sat_one(input sct_pkg::data_type v);
      sct_pkg::data_type r;
      if (v > ONE)       r = ONE;
      else if (v < -ONE) r = -ONE;
      else               r = v;
      return r;
   endfunction

   logic                               neg_ff, neg_in;
   sct_pkg::mag_type                   m_ff, m_in;
   sct_pkg::data_type                  x_ff, x_in, x2_ff, x2_in, acc_ff, acc_in;
   sct_pkg::data_type                  s_ff, s_in, c_ff, c_in, p_ff, p_in, q_ff, q_in;
   logic signed [sct_pkg::OUT_W-1:0]   sine_ff, sine_in, cosine_ff, cosine_in;

   sct_pkg::data_type  mul_a, mul_b, prod, coef, s_signed;
   sct_pkg::mag_type   ext_angle, rnd, red;

   assign rsp_sine_out   = sine_ff;
   assign rsp_cosine_out = cosine_ff;

   assign status.halve_more = m_ff > (sct_pkg::HALF_PI << cmd.shift);

   assign coef      = sct_pkg::coef_of(cmd.coef_idx);
   assign ext_angle = sct_pkg::MAG_W'(req_angle);
   assign rnd       = (sct_pkg::MAG_W'(1) << cmd.shift) >> 1;
   assign red       = (m_ff + rnd) >> cmd.shift;
   assign s_signed  = neg_ff ? -s_ff : s_ff;

   // operand select for the shared multiplier
   always_comb begin
      unique case (cmd.op)
         sct_pkg::OP_SQUARE: begin mul_a = x_ff;  mul_b = x_ff;   end
         sct_pkg::OP_SINE:   begin mul_a = x_ff;  mul_b = acc_ff; end
         sct_pkg::OP_DA_SC:  begin mul_a = s_ff;  mul_b = c_ff;   end
         sct_pkg::OP_DA_CC:  begin mul_a = c_ff;  mul_b = c_ff;   end
         sct_pkg::OP_DA_SS:  begin mul_a = s_ff;  mul_b = s_ff;   end
         default:            begin mul_a = x2_ff; mul_b = acc_ff; end
      endcase
   end

   assign prod = mulq(mul_a, mul_b);

   always_comb begin
      neg_in    = neg_ff;
      m_in      = m_ff;
      x_in      = x_ff;
      x2_in     = x2_ff;
      acc_in    = acc_ff;
      s_in      = s_ff;
      c_in      = c_ff;
      p_in      = p_ff;
      q_in      = q_ff;
      sine_in   = sine_ff;
      cosine_in = cosine_ff;
      unique case (cmd.op)
         sct_pkg::OP_LOAD: begin
            neg_in = req_angle[sct_pkg::ANGLE_W-1];
            m_in   = req_angle[sct_pkg::ANGLE_W-1] ? -ext_angle : ext_angle;
         end
         sct_pkg::OP_REDUCE: begin
            x_in = (red > sct_pkg::HALF_PI) ? sct_pkg::DATA_W'(sct_pkg::HALF_PI)
                                            : sct_pkg::DATA_W'(red);
         end
         sct_pkg::OP_SQUARE:   x2_in  = prod;
         sct_pkg::OP_ACC_INIT: acc_in = coef;
         sct_pkg::OP_HORNER:   acc_in = coef - prod;
         sct_pkg::OP_SINE:     s_in   = sat_one(prod);
         sct_pkg::OP_COSINE:   c_in   = sat_one(acc_ff);
         sct_pkg::OP_DA_SC:    p_in   = prod;
         sct_pkg::OP_DA_CC:    q_in   = prod;
         sct_pkg::OP_DA_SS: begin
            s_in = sat_one(p_ff <<< 1);
            c_in = sat_one(q_ff - prod);
         end
         sct_pkg::OP_EMIT: begin
            sine_in   = s_signed[sct_pkg::OUT_W-1:0];
            cosine_in = c_ff[sct_pkg::OUT_W-1:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      neg_ff    <= neg_in;
      m_ff      <= m_in;
      x_ff      <= x_in;
      x2_ff     <= x2_in;
      acc_ff    <= acc_in;
      s_ff      <= s_in;
      c_ff      <= c_in;
      p_ff      <= p_in;
      q_ff      <= q_in;
      sine_ff   <= sine_in;
      cosine_ff <= cosine_in;
   end

endmodule

// ----- verif/tb_sine_cosine_taylor_top.sv -----
// Self-checking testbench for the Taylor-series sine/cosine block.
`timescale 1ns / 1ps

module tb_sine_cosine_taylor_top;

   localparam int ANGLE_W = sct_pkg::ANGLE_W;
   localparam int OUT_W   = sct_pkg::OUT_W;

   // Arithmetic setup, partly taken from the block's package
   localparam int FRAC      = sct_pkg::FRAC_BITS;
   localparam int TERMS     = sct_pkg::TAYLOR_TERMS;
   localparam int HALVE_MAX = sct_pkg::MAX_HALVINGS;
   localparam int IN_FRAC   = 16;
   localparam int N_RECIP   = 2 * TERMS;

   // pi/2 in Q60, brought down to the working fraction width (round half up)
   localparam longint unsigned HALF_PI_Q60 = 64'h1921FB54442D1847;
   localparam longint unsigned HALF_PI_Q   =
      (HALF_PI_Q60 + (64'd1 << (59 - FRAC))) >> (60 - FRAC);

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 60;
   localparam int REPORT_MAX   = 100;   // mismatch lines printed before going quiet

   typedef logic signed [ANGLE_W-1:0] angle_type;

   typedef struct {
      angle_type               angle;
      logic signed [OUT_W-1:0] sine;
      logic signed [OUT_W-1:0] cosine;
   } sincos_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   angle_type                 req_angle = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [OUT_W-1:0]   rsp_sine_out;
   logic signed [OUT_W-1:0]   rsp_cosine_out;

   // Stimulus and expectation stores
   angle_type   angle_pending[$];
   sincos_type  sincos_due[$];
   longint      recip_fact[N_RECIP];

   // Idle controls, changed only at the falling edge, and the error and cycle counters
   int       send_idle_pct = 0;
   int       rsp_stall_pct = 0;
   int       error_count   = 0;
   int       cycle_count   = 0;

   sine_cosine_taylor_top u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_angle      (req_angle),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sine_out   (rsp_sine_out),
      .rsp_cosine_out (rsp_cosine_out)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------------------
   // Fixed-point predictor
   // ---------------------------------------------------------------------------

   // Product of magnitudes, rounded half away from zero, sign reapplied
   function automatic longint mul_round(input longint a, input longint b);
      longint unsigned ua, ub, p;
      logic            neg;
      neg = (a < 0) != (b < 0);
      ua  = (a < 0) ? -a : a;
      ub  = (b < 0) ? -b : b;
      p   = (ua * ub + (64'd1 << (FRAC - 1))) >> FRAC;
      return neg ? -longint'(p) : longint'(p);
   endfunction

   function automatic longint clamp_one(input longint v);
      longint one;
      one = longint'(1) << FRAC;
      if (v > one)  return one;
      if (v < -one) return -one;
      return v;
   endfunction

   // Horner sum of (-1)^i * x2^i / (2i + first)!
   function automatic longint taylor_sum(input longint x2, input int first);
      longint acc;
      acc = recip_fact[2 * (TERMS - 1) + first];
      for (int i = TERMS - 2; i >= 0; i--) begin
         acc = recip_fact[2 * i + first] - mul_round(x2, acc);
      end
      return acc;
   endfunction

   // Working value to Q1.16, saturated to +-1.0
   function automatic logic signed [OUT_W-1:0] to_out(input longint v);
      longint unsigned mag;
      int              d;
      d   = FRAC - IN_FRAC;
      mag = (v < 0) ? -v : v;
      if (d > 0) begin
         mag = (mag + (64'd1 << (d - 1))) >> d;
      end
      if (mag > (64'd1 << IN_FRAC)) begin
         mag = 64'd1 << IN_FRAC;
      end
      return (v < 0) ? -OUT_W'(mag) : OUT_W'(mag);
   endfunction

   function automatic sincos_type predict_sincos(input angle_type angle);
      sincos_type      r;
      longint unsigned mag;
      longint          x, x2, s, c, s2, c2;
      int              k;
      logic            neg;
      neg = angle[ANGLE_W-1];
      mag = neg ? (64'd1 << ANGLE_W) - longint'({1'b0, angle}) : longint'({1'b0, angle});
      mag = mag << (FRAC - IN_FRAC);
      // range reduction by halving; strict compare against pi/2 scaled up
      k = 0;
      while (k < HALVE_MAX && mag > (HALF_PI_Q << k)) begin
         k++;
      end
      if (k > 0) begin
         mag = (mag + (64'd1 << (k - 1))) >> k;
      end
      if (mag > HALF_PI_Q) begin
         mag = HALF_PI_Q;
      end
      x  = longint'(mag);
      x2 = mul_round(x, x);
      s  = clamp_one(mul_round(x, taylor_sum(x2, 1)));
      c  = clamp_one(taylor_sum(x2, 0));
      // undo the halvings with the double-angle rules
      for (int i = 0; i < k; i++) begin
         s2 = clamp_one(2 * mul_round(s, c));
         c2 = clamp_one(mul_round(c, c) - mul_round(s, s));
         s  = s2;
         c  = c2;
      end
      if (neg) begin
         s = -s;
      end
      r.angle  = angle;
      r.sine   = to_out(s);
      r.cosine = to_out(c);
      return r;
   endfunction

   // Reciprocal factorials: 2^62 divided down by 1, 2, 3, ... then rounded to FRAC
   initial begin
      longint unsigned r;
      r = 64'd1 << 62;
      for (int n = 0; n < N_RECIP; n++) begin
         if (n > 0) begin
            r = r / longint'(n);
         end
         recip_fact[n] = longint'((r + (64'd1 << (61 - FRAC))) >> (62 - FRAC));
      end
   end

   // ---------------------------------------------------------------------------
   // Driver: takes angles from the pending queue, one item per handshake.
   // The expectation is pushed at the edge where the item is accepted.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : angle_drive
      logic taken;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         taken = req_valid && req_ready;
         if (taken) begin
            sincos_due.push_back(predict_sincos(req_angle));
         end
         // payload stays put while valid waits for ready
         if (!req_valid || taken) begin
            if (angle_pending.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
               req_angle <= angle_pending.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Monitor: checks each accepted result against the oldest expectation,
   // and throttles rsp_ready at random.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : result_check
      sincos_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (sincos_due.size() == 0) begin
               if (error_count < REPORT_MAX) begin
                  $display("%0t: unexpected result: expected none, actual sine %0d cosine %0d",
                           $time, rsp_sine_out, rsp_cosine_out);
               end
               error_count++;
            end else begin
               want = sincos_due.pop_front();
               if (rsp_sine_out !== want.sine) begin
                  if (error_count < REPORT_MAX) begin
                     $display("%0t: angle %0d sine: expected %0d actual %0d",
                              $time, want.angle, want.sine, rsp_sine_out);
                  end
                  error_count++;
               end
               if (rsp_cosine_out !== want.cosine) begin
                  if (error_count < REPORT_MAX) begin
                     $display("%0t: angle %0d cosine: expected %0d actual %0d",
                              $time, want.angle, want.cosine, rsp_cosine_out);
                  end
                  error_count++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99, 0) >= rsp_stall_pct);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus phases. Shared state is touched only at the falling edge so the
   // clocked blocks never race with it.
   // ---------------------------------------------------------------------------
   task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
      longint unsigned mag;
      int              k;
      angle_type       a;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(3, 0))
            0, 1: begin
               // anything the field allows, every bit toggles
               a = angle_type'($urandom());
            end
            2: begin
               // no halving needed: within +-pi/2
               mag = $urandom_range(int'(HALF_PI_Q), 0);
               a   = $urandom_range(1, 0) ? -angle_type'(mag) : angle_type'(mag);
            end
            default: begin
               // straddle a halving threshold, pi/2 * 2^k
               k   = $urandom_range(HALVE_MAX - 1, 0);
               mag = (HALF_PI_Q << k) + $urandom_range(4, 0) - 2;
               a   = $urandom_range(1, 0) ? -angle_type'(mag) : angle_type'(mag);
            end
         endcase
         angle_pending.push_back(a);
      end
      while (angle_pending.size() != 0 || req_valid) begin
         @(negedge clock);
      end
      // hold off until the block has returned everything
      while (sincos_due.size() != 0) begin
         @(negedge clock);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: field extremes, zero, the halving thresholds, the most
      // negative angle and alternating bit patterns
      angle_pending.push_back('0);
      angle_pending.push_back(angle_type'(1));
      angle_pending.push_back(-angle_type'(1));
      angle_pending.push_back(angle_type'(22'h1FFFFF));
      angle_pending.push_back(angle_type'(22'h200000));
      angle_pending.push_back(angle_type'(65536));
      angle_pending.push_back(-angle_type'(65536));
      angle_pending.push_back(angle_type'(HALF_PI_Q / 2));
      for (int k = 0; k < HALVE_MAX; k++) begin
         angle_pending.push_back(angle_type'(HALF_PI_Q << k));
         angle_pending.push_back(-angle_type'((HALF_PI_Q << k) + 1));
         angle_pending.push_back(angle_type'((HALF_PI_Q << k) + 1));
      end
      angle_pending.push_back(angle_type'(22'h2AAAAA));
      angle_pending.push_back(angle_type'(22'h155555));

      // Idle mixes, each run twice so gaps land on every step of the block
      for (int rep = 0; rep < 2; rep++) begin
         run_phase(0, 0, 179);
         run_phase(72, 0, 179);
         run_phase(0, 72, 179);
         run_phase(18, 18, 179);
      end

      while (sincos_due.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && sincos_due.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
